FILE: rtl/dcps_pkg.sv
package dcps_pkg;

  // sequence memory depth per channel
  localparam int SEQ_DEPTH = 256;
  localparam int ADDR_W    = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
  // position and length hold 0 .. SEQ_DEPTH
  localparam int POS_W     = $clog2(SEQ_DEPTH + 1);
  localparam int CNT_W     = 17;
  localparam int POLL_W    = 16;

  localparam logic [CNT_W-1:0] EXHAUSTED_WAIT = 17'h10000;

  // request codes
  localparam logic [1:0] REQ_LOAD_A = 2'd0;
  localparam logic [1:0] REQ_LOAD_B = 2'd1;
  localparam logic [1:0] REQ_START  = 2'd2;
  localparam logic [1:0] REQ_SAMPLE = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_SAFE_A    = 3'd0;
  localparam logic [2:0] CFG_SAFE_B    = 3'd1;
  localparam logic [2:0] CFG_MASK_A    = 3'd2;
  localparam logic [2:0] CFG_MASK_B    = 3'd3;
  localparam logic [2:0] CFG_FIXED_A   = 3'd4;
  localparam logic [2:0] CFG_FIXED_B   = 3'd5;
  localparam logic [2:0] CFG_CLK_MASK  = 3'd6;
  localparam logic [2:0] CFG_POLL_LIM  = 3'd7;

  // per-channel word shaping
  typedef struct packed {
    logic [7:0] safe;
    logic [7:0] mask;
    logic [7:0] fixed;
  } chan_cfg_t;

  // commands from the sequencer control to one channel
  typedef struct packed {
    logic             load;
    logic [7:0]       load_index;
    logic [7:0]       load_code;
    logic [7:0]       load_repeat;
    logic             start;
    logic [8:0]       start_len;
    logic [15:0]      start_delay;
    logic             tick;
  } chan_ctl_t;

  // channel status back to the control
  typedef struct packed {
    logic       fire;
    logic [7:0] word;
    logic       more;
  } chan_stat_t;

  function automatic logic [7:0] drive_word(input logic [7:0] w, input logic [7:0] mask,
                                            input logic [7:0] fixed);
    drive_word = (w & mask) | fixed;
  endfunction

endpackage

FILE: rtl/dcps_if.sv
interface dcps_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  entry_index;
  logic [7:0]  entry_code;
  logic [7:0]  entry_repeat;
  logic [8:0]  length_a;
  logic [8:0]  length_b;
  logic [15:0] delay_a;
  logic [15:0] delay_b;
  logic [7:0]  clock_word;

  modport source (output valid, req_type, entry_index, entry_code, entry_repeat,
                  length_a, length_b, delay_a, delay_b, clock_word, input ready);
  modport sink (input valid, req_type, entry_index, entry_code, entry_repeat,
                length_a, length_b, delay_a, delay_b, clock_word, output ready);
endinterface

interface dcps_rsp_if;
  logic       valid;
  logic       ready;
  logic       port_a_write;
  logic [7:0] port_a_value;
  logic       port_b_write;
  logic [7:0] port_b_value;
  logic       running;
  logic       finished;
  logic       timed_out;

  modport source (output valid, port_a_write, port_a_value, port_b_write, port_b_value,
                  running, finished, timed_out, input ready);
  modport sink (input valid, port_a_write, port_a_value, port_b_write, port_b_value,
                running, finished, timed_out, output ready);
endinterface

FILE: rtl/dcps_ram.sv
module dcps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/dcps_chan.sv
module dcps_chan (
  input  logic              clk,
  input  logic              rst,
  input  dcps_pkg::chan_cfg_t  cfg,
  input  dcps_pkg::chan_ctl_t  ctl,
  output dcps_pkg::chan_stat_t stat
);
  import dcps_pkg::*;

  logic [CNT_W-1:0]  countdown;
  logic [POS_W-1:0]  position;
  logic [POS_W-1:0]  run_length;
  logic [15:0]       rd_entry;
  logic              wr_ok;
  logic              avail;
  logic [POS_W-1:0]  len_clamped;

  // code in the high byte, repeat in the low byte
  assign wr_ok = ctl.load && (32'(ctl.load_index) < SEQ_DEPTH);

  dcps_ram #(.WIDTH(16), .DEPTH(SEQ_DEPTH)) u_ram (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (ADDR_W'(ctl.load_index)),
    .wdata ({ctl.load_code, ctl.load_repeat}),
    .raddr (ADDR_W'(position)),
    .rdata (rd_entry)
  );

  // entry left at the current position
  assign avail = (position != run_length) && (32'(position) < SEQ_DEPTH);

  assign len_clamped = (32'(ctl.start_len) > SEQ_DEPTH) ? POS_W'(SEQ_DEPTH)
                                                        : POS_W'(ctl.start_len);

  // fires while the countdown stands at one
  always_comb begin
    stat.fire = (countdown == CNT_W'(1));
    stat.word = drive_word(avail ? rd_entry[15:8] : cfg.safe, cfg.mask, cfg.fixed);
    stat.more = (position < run_length);
  end

  // countdown, position and length
  always_ff @(posedge clk) begin
    if (rst) begin
      countdown  <= '0;
      position   <= '0;
      run_length <= '0;
    end else if (ctl.start) begin
      countdown  <= CNT_W'(ctl.start_delay) + CNT_W'(1);
      position   <= '0;
      run_length <= len_clamped;
    end else if (ctl.tick && countdown != '0) begin
      if (countdown == CNT_W'(1)) begin
        if (avail) begin
          countdown <= CNT_W'(rd_entry[7:0]);
          position  <= position + POS_W'(1);
        end else begin
          countdown <= EXHAUSTED_WAIT;
        end
      end else begin
        countdown <= countdown - CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/dual_channel_pulse_sequencer.sv
// channel  dir  handshake     payload
// cmd      in   valid/ready   req_type, entry fields, lengths, delays, clock_word
// rsp      out  valid/ready   port a/b write and value, running, finished, timed_out
// cfg      in   cfg_write     cfg_index, cfg_data (no read-back)
//
// load and start items go straight to the output register; a clock sample passes
// through the ST_SAMPLE state first, since the entry at each channel's position
// comes from its registered sequence memory. one item is in flight at a time.
// a result waits in an output register; the next item is taken as that
// register drains. synchronous reset clears control state, configuration registers
// and the output valid flag; memories, the held sample and output payload are not cleared.
module dual_channel_pulse_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  dcps_cmd_if.sink    cmd,
  dcps_rsp_if.source  rsp
);
  import dcps_pkg::*;

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_SAMPLE = 1'b1;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LOW  = 2'd1;
  localparam logic [1:0] PH_HIGH = 2'd2;

  // configuration registers
  logic [7:0]        safe_a, safe_b, mask_a, mask_b, fixed_a, fixed_b, clk_mask;
  logic [POLL_W-1:0] poll_limit;

  // control state
  logic              state;
  logic [1:0]        wait_phase, wait_phase_next;
  logic [POLL_W-1:0] poll_count, poll_count_next;
  logic [7:0]        sample_word;

  // output register
  logic       out_valid;
  logic       o_wa, o_wb, o_run, o_fin, o_tmo;
  logic [7:0] o_va, o_vb;

  logic       take;
  logic       sample_done;
  chan_cfg_t  cfg_a, cfg_b;
  chan_ctl_t  ctl_a, ctl_b;
  chan_stat_t stat_a, stat_b;

  // sample evaluation
  logic [POLL_W-1:0] lim;
  logic [POLL_W:0]   cnt;
  logic              high, edge_seen, tmo, fin, tick;

  always_ff @(posedge clk) begin
    if (rst) begin
      safe_a     <= '0;
      safe_b     <= '0;
      mask_a     <= 8'hFF;
      mask_b     <= 8'hFF;
      fixed_a    <= '0;
      fixed_b    <= '0;
      clk_mask   <= 8'h01;
      poll_limit <= 16'd10000;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SAFE_A:   safe_a     <= cfg_data[7:0];
        CFG_SAFE_B:   safe_b     <= cfg_data[7:0];
        CFG_MASK_A:   mask_a     <= cfg_data[7:0];
        CFG_MASK_B:   mask_b     <= cfg_data[7:0];
        CFG_FIXED_A:  fixed_a    <= cfg_data[7:0];
        CFG_FIXED_B:  fixed_b    <= cfg_data[7:0];
        CFG_CLK_MASK: clk_mask   <= cfg_data[7:0];
        CFG_POLL_LIM: poll_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_a = '{safe: safe_a, mask: mask_a, fixed: fixed_a};
  assign cfg_b = '{safe: safe_b, mask: mask_b, fixed: fixed_b};

  // item handshake
  assign cmd.ready = (state == ST_IDLE) && (!out_valid || rsp.ready);
  assign take      = cmd.valid && cmd.ready;
  assign sample_done = (state == ST_SAMPLE);

  // clock wait evaluation on the held sample
  always_comb begin
    lim       = (poll_limit == '0) ? POLL_W'(1) : poll_limit;
    cnt       = {1'b0, poll_count} + (POLL_W+1)'(1);
    high      = (sample_word & clk_mask) != 8'h00;
    edge_seen = (wait_phase == PH_LOW) ? !high : high;
    tmo       = 1'b0;
    fin       = 1'b0;
    tick      = 1'b0;
    wait_phase_next = wait_phase;
    poll_count_next = poll_count;
    if (wait_phase == PH_LOW || wait_phase == PH_HIGH) begin
      if (cnt >= {1'b0, lim}) begin
        tmo = 1'b1;
        poll_count_next = '0;
        wait_phase_next = PH_IDLE;
      end else if (!edge_seen) begin
        poll_count_next = cnt[POLL_W-1:0];
      end else begin
        poll_count_next = '0;
        if (wait_phase == PH_LOW) begin
          tick = 1'b1;
          wait_phase_next = PH_HIGH;
        end else if (stat_a.more || stat_b.more) begin
          wait_phase_next = PH_LOW;
        end else begin
          fin = 1'b1;
          wait_phase_next = PH_IDLE;
        end
      end
    end
  end

  // channel commands
  always_comb begin
    ctl_a.load        = take && (cmd.req_type == REQ_LOAD_A);
    ctl_a.load_index  = cmd.entry_index;
    ctl_a.load_code   = cmd.entry_code;
    ctl_a.load_repeat = cmd.entry_repeat;
    ctl_a.start       = take && (cmd.req_type == REQ_START);
    ctl_a.start_len   = cmd.length_a;
    ctl_a.start_delay = cmd.delay_a;
    ctl_a.tick        = sample_done && tick;
    ctl_b             = ctl_a;
    ctl_b.load        = take && (cmd.req_type == REQ_LOAD_B);
    ctl_b.start_len   = cmd.length_b;
    ctl_b.start_delay = cmd.delay_b;
  end

  dcps_chan u_chan_a (.clk(clk), .rst(rst), .cfg(cfg_a), .ctl(ctl_a), .stat(stat_a));
  dcps_chan u_chan_b (.clk(clk), .rst(rst), .cfg(cfg_b), .ctl(ctl_b), .stat(stat_b));

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      wait_phase <= PH_IDLE;
      poll_count <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (take && cmd.req_type == REQ_SAMPLE) begin
            state <= ST_SAMPLE;
          end else if (take && cmd.req_type == REQ_START) begin
            wait_phase <= PH_LOW;
            poll_count <= '0;
          end
        end
        ST_SAMPLE: begin
          state      <= ST_IDLE;
          wait_phase <= wait_phase_next;
          poll_count <= poll_count_next;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      sample_word <= cmd.clock_word;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && cmd.req_type != REQ_SAMPLE) begin
      out_valid <= 1'b1;
    end else if (sample_done) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && cmd.req_type == REQ_START) begin
      o_wa  <= 1'b1;
      o_va  <= drive_word(safe_a, mask_a, fixed_a);
      o_wb  <= 1'b1;
      o_vb  <= drive_word(safe_b, mask_b, fixed_b);
      o_run <= 1'b1;
      o_fin <= 1'b0;
      o_tmo <= 1'b0;
    end else if (take && cmd.req_type != REQ_SAMPLE) begin
      o_wa  <= 1'b0;
      o_va  <= '0;
      o_wb  <= 1'b0;
      o_vb  <= '0;
      o_run <= (wait_phase != PH_IDLE);
      o_fin <= 1'b0;
      o_tmo <= 1'b0;
    end else if (sample_done) begin
      o_wa  <= tick && stat_a.fire;
      o_va  <= (tick && stat_a.fire) ? stat_a.word : 8'h00;
      o_wb  <= tick && stat_b.fire;
      o_vb  <= (tick && stat_b.fire) ? stat_b.word : 8'h00;
      o_run <= (wait_phase_next != PH_IDLE);
      o_fin <= fin;
      o_tmo <= tmo;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.port_a_write = o_wa;
  assign rsp.port_a_value = o_va;
  assign rsp.port_b_write = o_wb;
  assign rsp.port_b_value = o_vb;
  assign rsp.running      = o_run;
  assign rsp.finished     = o_fin;
  assign rsp.timed_out    = o_tmo;

endmodule
